[rtl/core/sem_pkg.sv]
// Shared constants and types for the Sobel edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

  localparam int MaxWidth   = 2048;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = 16;
  localparam int PixW       = 8;
  localparam int WidthRegW  = 12;
  localparam int HeightRegW = 16;
  localparam int MinDim     = 3;

  localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(640);
  localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(480);

  localparam int PaddrW   = 3;
  localparam int ApbDataW = 32;

  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  // gray = floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
  localparam int SumW     = 10;
  localparam int Div3Mul  = 683;
  localparam int Div3Shft = 11;

  localparam int GradW   = 11;
  localparam int SqW     = 21;
  localparam int RootW   = 8;
  localparam int RootSqW = 2 * RootW;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [RowW-1:0] row_t;
  typedef logic [ColW-1:0] col_t;

endpackage
`default_nettype wire

[rtl/core/sem_if.sv]
// Pixel and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface sem_pix_if;
  import sem_pkg::*;
  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface sem_res_if;
  import sem_pkg::*;
  logic valid;
  logic ready;
  row_t out_row;
  col_t out_col;
  pix_t edge_res;
  logic last;
  modport source (output valid, out_row, out_col, edge_res, last, input ready);
  modport sink (input valid, out_row, out_col, edge_res, last, output ready);
endinterface
`default_nettype wire

[rtl/core/sem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/sem_root.sv]
// Iterative clamped integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sem_root (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sem_pkg::SqW-1:0]   sum_i,
  output logic                           done_o,
  output logic      [sem_pkg::RootW-1:0] root_o
);
  import sem_pkg::*;

  localparam int StepW = $clog2(RootW);

  logic                busy_q;
  logic                done_q;
  logic [StepW-1:0]    step_q;
  logic [RootW-1:0]    root_q;
  logic [RootSqW-1:0]  s_q;
  logic [RootW-1:0]    trial;
  logic [RootSqW-1:0]  trial_sq;

  assign trial    = root_q | (RootW'(1) << (StepW'(RootW - 1) - step_q));
  assign trial_sq = RootSqW'(trial) * RootSqW'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      root_q <= '0;
      s_q    <= '0;
    end else begin
      done_q <= start_i ? |sum_i[SqW-1:RootSqW]
                        : (busy_q && (step_q == StepW'(RootW - 1)));
      if (start_i) begin
        if (|sum_i[SqW-1:RootSqW]) begin
          root_q <= '1;
        end else begin
          s_q    <= sum_i[RootSqW-1:0];
          root_q <= '0;
          step_q <= '0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (trial_sq <= s_q) begin
          root_q <= trial;
        end
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(RootW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

[rtl/core/sobel_edge_magnitude.sv]
// Streaming 3x3 Sobel edge magnitude over gray-converted RGB pixels.
//
//   channel  dir  handshake       payload
//   pix_i    in   valid/ready     red, green, blue
//   res_o    out  valid/ready     out_row, out_col, edge_res, last
//   apb      in   psel/penable    paddr 0: image_width, paddr 4: image_height
//
// Items are taken one at a time: each goes through fetch, gradient, square,
// root and emit before the next is taken, and an item may emit no result. The
// eight-step square root sets most of an item's time unless the gradient sum saturates.
// The line stores are read at the accept edge and written in the fetch state that follows.
// A stalled result holds the output register; the next item is taken once
// the final result of the current one sits in that register.
// Reset clears counters, window and config (640 x 480); line stores are not.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sem_pkg::PaddrW-1:0]     paddr,
  input  wire logic [sem_pkg::ApbDataW-1:0]   pwdata,
  output logic      [sem_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready,
  sem_pix_if.sink                             pix_i,
  sem_res_if.source                           res_o
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT
  } state_e;

  localparam logic [1:0] SlotInner  = 2'd0;
  localparam logic [1:0] SlotRight  = 2'd1;
  localparam logic [1:0] SlotBottom = 2'd2;
  localparam logic [1:0] SlotCorner = 2'd3;

  state_e                 state_q;
  logic [WidthRegW-1:0]   image_width_q;
  logic [HeightRegW-1:0]  image_height_q;
  row_t                   row_q;
  col_t                   col_q;
  row_t                   r_q;
  col_t                   c_q;
  pix_t                   gray_q;
  pix_t                   win_q [9];
  logic signed [GradW-1:0] gx_q, gy_q;
  logic [SqW-1:0]         sq_x_q, sq_y_q;
  logic                   root_go_q;
  pix_t                   mag_q;
  logic                   edge_ok_q;
  logic [3:0]             res_q;
  logic                   out_valid_q;
  row_t                   out_row_q;
  col_t                   out_col_q;
  pix_t                   out_edge_q;
  logic                   out_last_q;

  logic                   cfg_wr;
  logic [WidthRegW-1:0]   w_eff;
  col_t                   w_last;
  row_t                   h_last;
  col_t                   c_cur;
  row_t                   r_cur;
  logic                   lastc, lastr;
  logic                   in_acc;
  logic [SumW-1:0]        pix_sum;
  logic [SumW+Div3Shft-1:0] div_prod;
  pix_t                   rd_a, rd_b, mid, top;
  logic signed [GradW-1:0] gx, gy;
  logic signed [2*GradW-1:0] prod_x, prod_y;
  logic                   root_done;
  pix_t                   root_val;
  logic                   out_free;
  logic                   out_load;
  logic [1:0]             sel;
  logic [3:0]             rest;
  row_t                   sel_row;
  col_t                   sel_col;
  pix_t                   sel_edge;

  function automatic logic signed [GradW-1:0] ext(input pix_t p);
    return $signed({{(GradW-PixW){1'b0}}, p});
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      RegImageWidth:  prdata = ApbDataW'(image_width_q);
      RegImageHeight: prdata = ApbDataW'(image_height_q);
      default:        prdata = '0;
    endcase
  end

  // effective geometry and clamped position
  always_comb begin
    if (image_width_q < WidthRegW'(MinDim)) begin
      w_eff = WidthRegW'(MinDim);
    end else if (image_width_q > WidthRegW'(MaxWidth)) begin
      w_eff = WidthRegW'(MaxWidth);
    end else begin
      w_eff = image_width_q;
    end
  end
  assign w_last = ColW'(w_eff - 1'b1);
  assign h_last = (image_height_q < HeightRegW'(MinDim)) ? RowW'(MinDim - 1)
                                                          : RowW'(image_height_q - 1'b1);
  assign c_cur  = (col_q > w_last) ? w_last : col_q;
  assign r_cur  = (row_q > h_last) ? h_last : row_q;
  assign lastc  = (c_cur == w_last);
  assign lastr  = (r_cur == h_last);

  assign pix_i.ready = (state_q == ST_IDLE);
  assign in_acc      = pix_i.valid && (state_q == ST_IDLE);

  assign pix_sum  = SumW'(pix_i.red) + SumW'(pix_i.green) + SumW'(pix_i.blue);
  assign div_prod = (SumW+Div3Shft)'(pix_sum) * (SumW+Div3Shft)'(Div3Mul);

  // line stores
  assign mid = (r_q != '0) ? rd_a : '0;
  assign top = (r_q > RowW'(1)) ? rd_b : '0;

  sem_ram #(.WIDTH(PixW), .DEPTH(MaxWidth)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_FETCH),
    .waddr_i (c_q),
    .wdata_i (gray_q),
    .raddr_i (c_cur),
    .rdata_o (rd_a)
  );

  sem_ram #(.WIDTH(PixW), .DEPTH(MaxWidth)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_FETCH),
    .waddr_i (c_q),
    .wdata_i (mid),
    .raddr_i (c_cur),
    .rdata_o (rd_b)
  );

  // kernels
  assign gx = (ext(win_q[2]) + (ext(win_q[5]) <<< 1) + ext(win_q[8]))
            - (ext(win_q[0]) + (ext(win_q[3]) <<< 1) + ext(win_q[6]));
  assign gy = (ext(win_q[0]) + (ext(win_q[1]) <<< 1) + ext(win_q[2]))
            - (ext(win_q[6]) + (ext(win_q[7]) <<< 1) + ext(win_q[8]));
  assign prod_x = gx_q * gx_q;
  assign prod_y = gy_q * gy_q;

  sem_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_go_q),
    .sum_i   (sq_x_q + sq_y_q),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  // result selection, lowest pending slot first
  always_comb begin
    sel = SlotInner;
    for (int i = 3; i >= 0; i--) begin
      if (res_q[i]) begin
        sel = 2'(i);
      end
    end
    rest = res_q & ~(4'b0001 << sel);
  end

  always_comb begin
    case (sel)
      SlotInner: begin
        sel_row  = r_q - 1'b1;
        sel_col  = c_q - 1'b1;
        sel_edge = edge_ok_q ? mag_q : '0;
      end
      SlotRight: begin
        sel_row  = r_q - 1'b1;
        sel_col  = c_q;
        sel_edge = '0;
      end
      SlotBottom: begin
        sel_row  = r_q;
        sel_col  = c_q - 1'b1;
        sel_edge = '0;
      end
      SlotCorner: begin
        sel_row  = r_q;
        sel_col  = c_q;
        sel_edge = '0;
      end
    endcase
  end

  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = (state_q == ST_EMIT) && (res_q != '0) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
      row_q          <= '0;
      col_q          <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      root_go_q      <= 1'b0;
      res_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      root_go_q   <= (state_q == ST_SQUARE);
      out_valid_q <= out_load || (out_valid_q && !res_o.ready);
      if (cfg_wr) begin
        unique case (paddr[2])
          RegImageWidth:  image_width_q  <= pwdata[WidthRegW-1:0];
          RegImageHeight: image_height_q <= pwdata[HeightRegW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            r_q       <= r_cur;
            c_q       <= c_cur;
            gray_q    <= div_prod[Div3Shft +: PixW];
            edge_ok_q <= (r_cur > RowW'(1)) && (c_cur > ColW'(1));
            res_q     <= {lastr && lastc,
                          lastr && (c_cur != '0),
                          (r_cur != '0) && lastc,
                          (r_cur != '0) && (c_cur != '0)};
            if (lastc) begin
              col_q <= '0;
              row_q <= lastr ? '0 : r_cur + 1'b1;
            end else begin
              col_q <= c_cur + 1'b1;
              row_q <= r_cur;
            end
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          for (int k = 0; k < 3; k++) begin
            win_q[k*3]   <= win_q[k*3+1];
            win_q[k*3+1] <= win_q[k*3+2];
          end
          win_q[2] <= top;
          win_q[5] <= mid;
          win_q[8] <= gray_q;
          state_q  <= ST_GRAD;
        end
        ST_GRAD: begin
          gx_q    <= gx;
          gy_q    <= gy;
          state_q <= ST_SQUARE;
        end
        ST_SQUARE: begin
          sq_x_q    <= SqW'(prod_x);
          sq_y_q    <= SqW'(prod_y);
          state_q   <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            mag_q   <= root_val;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (res_q == '0) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_row_q   <= sel_row;
            out_col_q   <= sel_col;
            out_edge_q  <= sel_edge;
            out_last_q  <= (rest == '0);
            res_q       <= rest;
            if (rest == '0) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.out_row  = out_row_q;
  assign res_o.out_col  = out_col_q;
  assign res_o.edge_res = out_edge_q;
  assign res_o.last     = out_last_q;

endmodule
`default_nettype wire

[rtl/core/sem_checker.sv]
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sem_checker (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic [sem_pkg::RowW-1:0] out_row_i,
  input wire logic [sem_pkg::ColW-1:0] out_col_i,
  input wire logic [sem_pkg::PixW-1:0] out_edge_i,
  input wire logic                  out_last_i
);
  import sem_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({out_row_i, out_col_i, out_edge_i, out_last_i}))
    else $error("stalled result item changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while previous item in work");

  a_results_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready while results of an item remain");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result item right after accept");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_row_i   (res_o.out_row),
  .out_col_i   (res_o.out_col),
  .out_edge_i  (res_o.edge_res),
  .out_last_i  (res_o.last)
);
`default_nettype wire
